@@ rtl/arpfx_pkg.sv @@
// ----------------------------------------------------------------------------
// arpfx_pkg: shared types and constants for the range-to-prefix block
// Address width, word layouts, the queue entry and the prefix length encoder.
// ----------------------------------------------------------------------------
package arpfx_pkg;

	localparam int ADDR_BITS   = 32;
	localparam int REM_BITS    = ADDR_BITS + 1;     // range size, up to 2**ADDR_BITS
	localparam int LEN_BITS    = 6;
	localparam int IN_DATA_W   = 2 * ADDR_BITS;     // range_start, range_end
	localparam int OUT_DATA_W  = 40;                // prefix_base, prefix_length, pad
	localparam int OUT_USER_W  = 1;                 // range_empty

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [REM_BITS-1:0]  rem_t;
	typedef logic [LEN_BITS-1:0]  len_t;

	// classified range as it waits for the back end
	typedef struct packed {
		logic  empty;
		addr_t start;
		rem_t  remain;   // end - start + 1
	} range_entry_t;

	// one-hot block size (2**k) to prefix length (ADDR_BITS - k)
	function automatic len_t prefix_len(input rem_t onehot);
		len_t k;
		k = '0;
		for (int i = 0; i < REM_BITS; i++) begin
			if (onehot[i]) begin
				k = k | len_t'(i);
			end
		end
		return len_t'(ADDR_BITS) - k;
	endfunction

endpackage

@@ rtl/address_range_to_prefixes_top.sv @@
// ----------------------------------------------------------------------------
// address_range_to_prefixes_top: address range to aligned prefix list
// Splits an inclusive 32-bit range into the minimal ascending prefix list.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one word per range: start in the low 32 bits, end above.
//   Master side gives one word per prefix: base and length in tdata, tuser
//   flags an empty range (start above end; base and length zero), tlast
//   marks the final prefix of each range.
// Path: the first prefix of a range passes the input stage, the queue write,
//   the generator load and the output register before it is valid.
// Throughput: after a load step the generator gives one prefix per cycle while
//   m_tready allows, up to 62 prefixes per range; that per-block loop in
//   the generator sets the rate. The input stage and a QUEUE_DEPTH-entry
//   queue keep taking ranges while the generator is busy.
// Reset: arst_n clears the input stage, the queue and the generator; any
//   range in flight is dropped.
// Stall: while m_tready is low the output word holds and the generator
//   pauses; the queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
module address_range_to_prefixes_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [arpfx_pkg::IN_DATA_W-1:0]    s_tdata,   // range_start, range_end
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [arpfx_pkg::OUT_DATA_W-1:0]   m_tdata,   // prefix_base, prefix_length, zero pad
	output logic [arpfx_pkg::OUT_USER_W-1:0]   m_tuser,   // range_empty
	output logic                               m_tlast    // last_prefix
);
	import arpfx_pkg::*;

	logic         push_valid;
	logic         push_ready;
	range_entry_t push_data;
	logic         pop_valid;
	logic         pop_ready;
	range_entry_t pop_data;

	// classify and size each range
	arpfx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// buffered ranges waiting for the generator
	arpfx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// one aligned block per cycle while the output is not stalled
	arpfx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_ready  (pop_ready),
		.q_data   (pop_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/arpfx_front.sv @@
// ----------------------------------------------------------------------------
// arpfx_front: input stage
// Takes a range word, flags empty ranges, precomputes the range size.
// ----------------------------------------------------------------------------
module arpfx_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [arpfx_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output arpfx_pkg::range_entry_t              push_data
);
	import arpfx_pkg::*;

	logic         valid_s1;
	range_entry_t entry_s1;
	addr_t        start_w;
	addr_t        end_w;
	range_entry_t entry_d;

	assign start_w = s_tdata[ADDR_BITS-1:0];
	assign end_w   = s_tdata[IN_DATA_W-1:ADDR_BITS];

	always_comb begin
		entry_d.empty  = (start_w > end_w);
		entry_d.start  = start_w;
		entry_d.remain = {1'b0, end_w} - {1'b0, start_w} + rem_t'(1);
	end

	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

@@ rtl/arpfx_queue.sv @@
// ----------------------------------------------------------------------------
// arpfx_queue: small FIFO of classified ranges
// Decouples the input stage from the prefix generator.
// ----------------------------------------------------------------------------
module arpfx_queue #(
	parameter int DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  arpfx_pkg::range_entry_t push_data,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output arpfx_pkg::range_entry_t pop_data
);
	import arpfx_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	range_entry_t           mem [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/arpfx_back.sv @@
// ----------------------------------------------------------------------------
// arpfx_back: prefix generator
// Walks a range one aligned block per cycle, unless the output stalls, into a registered output word.
// ----------------------------------------------------------------------------
module arpfx_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	output logic                                  q_ready,
	input  arpfx_pkg::range_entry_t               q_data,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [arpfx_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [arpfx_pkg::OUT_USER_W-1:0]      m_tuser,
	output logic                                  m_tlast
);
	import arpfx_pkg::*;

	logic   busy_q;
	logic   empty_q;
	addr_t  cursor_q;
	rem_t   remain_q;

	logic   out_valid_q;
	addr_t  out_base_q;
	len_t   out_len_q;
	logic   out_empty_q;
	logic   out_last_q;

	rem_t   cur_ext;
	rem_t   align_blk;    // lowest set bit of cursor, 2**ADDR_BITS at zero
	rem_t   smear;        // remain with every bit below its top one set
	rem_t   fit_blk;      // largest power of two not above remain
	rem_t   blk;
	logic   is_last;
	logic   fire;

	always_comb begin
		cur_ext   = {1'b1, cursor_q};
		align_blk = cur_ext & (~cur_ext + rem_t'(1));
		smear     = remain_q;
		smear     = smear | (smear >> 1);
		smear     = smear | (smear >> 2);
		smear     = smear | (smear >> 4);
		smear     = smear | (smear >> 8);
		smear     = smear | (smear >> 16);
		smear     = smear | (smear >> 32);
		fit_blk   = smear & ~(smear >> 1);
		// aligned block fits when it is no higher than the fitting one
		blk       = ((align_blk & smear) != '0) ? align_blk : fit_blk;
		is_last   = empty_q || (remain_q == blk);
	end

	assign q_ready = !busy_q;
	assign fire    = busy_q && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q && q_valid) begin
				busy_q <= 1'b1;
			end else if (fire && is_last) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && q_valid) begin
			cursor_q <= q_data.start;
			remain_q <= q_data.remain;
			empty_q  <= q_data.empty;
		end else if (fire) begin
			cursor_q <= cursor_q + blk[ADDR_BITS-1:0];
			remain_q <= remain_q - blk;
		end
		if (fire) begin
			out_base_q  <= empty_q ? '0 : cursor_q;
			out_len_q   <= empty_q ? '0 : prefix_len(blk);
			out_empty_q <= empty_q;
			out_last_q  <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - ADDR_BITS - LEN_BITS){1'b0}}, out_len_q, out_base_q};
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_remain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !empty_q |-> remain_q != '0)
		else $error("range size zero while walking");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && out_base_q == '0 && out_len_q == '0)
		else $error("empty result not a lone zero word");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_len_q <= len_t'(ADDR_BITS))
		else $error("prefix length out of range");

	a_block_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !empty_q |-> $onehot(blk) && blk <= remain_q)
		else $error("block size not a single fitting power of two");
`endif

endmodule
